### sv/pbm_pkg.sv
package pbm_pkg;

    // Register stages from the input register to the output register
    localparam int PIPE_DEPTH = 6;
    localparam int LAST_STAGE = PIPE_DEPTH - 1;

    localparam logic [7:0] PIX_MAX = 8'd255;

    typedef enum logic [2:0] {
        MODE_ADD        = 3'd0,
        MODE_SUBTRACT   = 3'd1,
        MODE_MULTIPLY   = 3'd2,
        MODE_DIFFERENCE = 3'd3,
        MODE_DIVIDE     = 3'd4
    } t_blend_mode;

    // Captured input item
    typedef struct packed {
        t_blend_mode mode;
        logic [7:0]  blend;
        logic [7:0]  base;
    } t_in;

    // Restoring divider state: partial remainder, quotient so far, dividend bits to go
    typedef struct packed {
        logic [7:0] rem;
        logic [7:0] quot;
        logic [7:0] lo;
    } t_div;

    // Payload carried through the arithmetic stages
    typedef struct packed {
        logic [7:0]  res;
        logic        use_mul;
        logic        use_div;
        logic [15:0] prod;
        logic [7:0]  divisor;
        t_div        div;
    } t_lane;

    // Two quotient bits per call
    function automatic t_div div_step2(t_div d, logic [7:0] divisor);
        t_div       o;
        logic [8:0] trial;
        o = d;
        for (int i = 0; i < 2; i++) begin
            trial = {o.rem, o.lo[7]};
            o.lo  = {o.lo[6:0], 1'b0};
            if (trial >= {1'b0, divisor}) begin
                o.rem  = 8'(trial - {1'b0, divisor});
                o.quot = {o.quot[6:0], 1'b1};
            end else begin
                o.rem  = trial[7:0];
                o.quot = {o.quot[6:0], 1'b0};
            end
        end
        return o;
    endfunction

    // floor(p / 255) for p up to 255*255: estimate p >> 8, then one correction
    function automatic logic [7:0] div_by_255(logic [15:0] p);
        logic [7:0] q0;
        logic [8:0] r;
        q0 = p[15:8];
        r  = {1'b0, p[7:0]} + {1'b0, q0};
        return (r >= {1'b0, PIX_MAX}) ? 8'(q0 + 8'd1) : q0;
    endfunction

endpackage

### sv/pixel_blend_mode_unit.sv
// Channel   Direction  Handshake                  Payload
// ------------------------------------------------------------------------------
// in        sink       i_in_valid / o_in_stall    i_blend_pixel, i_base_pixel
// out       source     o_out_valid / i_out_stall  o_result_pixel
// cfg       sink       i_cfg_valid / o_cfg_ready  i_cfg_data (blend_mode)
//
// One pixel pair is taken every clock unless o_in_stall is raised; an accepted item
// passes through the input register and lane registers 1 to 5 to the output. The
// depth is set by the divide mode: a restoring divider that resolves two quotient bits in each of four stages.
// Each stage moves on when it is empty or the next stage moves, so bubbles close
// up and a stalled output only backs up the stages that are full.
// Reset (synchronous, active low) clears the valid bits and sets the mode to add.
// The configuration port is always ready.
module pixel_blend_mode_unit
    import pbm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,

    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_blend_pixel,
    input  logic [7:0] i_base_pixel,

    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_result_pixel,

    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [2:0] i_cfg_data
);

    t_blend_mode           r_mode;
    logic [PIPE_DEPTH-1:0] r_vld;
    logic [PIPE_DEPTH-1:0] adv;
    t_in                   r_in;
    t_lane                 r_lane [1:LAST_STAGE];
    t_lane                 n_lane [1:LAST_STAGE];

    // Stage moves on when it holds nothing or its successor moves on
    always_comb begin
        adv[LAST_STAGE] = !r_vld[LAST_STAGE] || !i_out_stall;
        for (int k = LAST_STAGE - 1; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k + 1];
        end
    end

    assign o_in_stall     = !adv[0];
    assign o_out_valid    = r_vld[LAST_STAGE];
    assign o_result_pixel = r_lane[LAST_STAGE].res;
    assign o_cfg_ready    = 1'b1;

    // First arithmetic stage: simple modes, product, divide set-up
    logic [8:0]  sum9;
    logic [15:0] num;

    always_comb begin
        sum9 = {1'b0, r_in.base} + {1'b0, r_in.blend};
        // base * 255 as a shift and subtract
        num  = {r_in.base, 8'h00} - {8'h00, r_in.base};

        n_lane[1]          = '0;
        n_lane[1].prod     = 16'(r_in.base * r_in.blend);
        n_lane[1].divisor  = r_in.blend;
        n_lane[1].div.rem  = num[15:8];
        n_lane[1].div.quot = 8'h00;
        n_lane[1].div.lo   = num[7:0];

        unique case (r_in.mode)
            MODE_ADD: begin
                n_lane[1].res = sum9[8] ? PIX_MAX : sum9[7:0];
            end
            MODE_SUBTRACT: begin
                n_lane[1].res = (r_in.base > r_in.blend) ? 8'(r_in.base - r_in.blend)
                                                         : 8'h00;
            end
            MODE_MULTIPLY: begin
                n_lane[1].use_mul = 1'b1;
            end
            MODE_DIFFERENCE: begin
                n_lane[1].res = (r_in.base >= r_in.blend) ? 8'(r_in.base - r_in.blend)
                                                          : 8'(r_in.blend - r_in.base);
            end
            MODE_DIVIDE: begin
                // Both zero gives black; zero blend or base not below blend saturates
                if (r_in.blend == 8'h00 && r_in.base == 8'h00) begin
                    n_lane[1].res = 8'h00;
                end else if (r_in.blend == 8'h00 || r_in.base >= r_in.blend) begin
                    n_lane[1].res = PIX_MAX;
                end else begin
                    n_lane[1].use_div = 1'b1;
                end
            end
            default: begin
                n_lane[1].res = 8'h00;
            end
        endcase

        // Divider stages; fold in the multiply correction and the final quotient
        for (int k = 2; k <= LAST_STAGE; k++) begin
            n_lane[k]     = r_lane[k - 1];
            n_lane[k].div = div_step2(r_lane[k - 1].div, r_lane[k - 1].divisor);
            if (k == 2 && r_lane[k - 1].use_mul) begin
                n_lane[k].res = div_by_255(r_lane[k - 1].prod);
            end
            if (k == LAST_STAGE && r_lane[k - 1].use_div) begin
                n_lane[k].res = n_lane[k].div.quot;
            end
        end
    end

    // Control: valid bits and the mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_mode <= MODE_ADD;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_mode <= t_blend_mode'(i_cfg_data);
            end
            if (adv[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < PIPE_DEPTH; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= r_vld[k - 1];
                end
            end
        end
    end

    // Payload: load whenever the stage advances, hold otherwise
    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_in.mode  <= r_mode;
            r_in.blend <= i_blend_pixel;
            r_in.base  <= i_base_pixel;
        end
        for (int k = 1; k < PIPE_DEPTH; k++) begin
            if (adv[k]) begin
                r_lane[k] <= n_lane[k];
            end
        end
    end

endmodule

### verif/pixel_blend_mode_unit_test.sv
module pixel_blend_mode_unit_test;
    import pbm_pkg::*;

    localparam int CLK_HALF         = 5;
    localparam int RESET_CYCLES     = 3;
    localparam int DIRECTED_PAIRS   = 5;
    localparam int RANDOM_PHASES    = 16;
    localparam int ITEMS_PER_PHASE  = 97;
    localparam int MODE_CODES       = 8;     // every code the 3-bit register can hold
    localparam int PAUSE_PHASE      = 3;     // phase in which the sender drains mid-stream
    localparam int PAUSE_ITEM       = 40;
    localparam int LONG_HOLD_AT     = 520;   // items accepted before the long output hold
    localparam int LONG_HOLD_CYCLES = 80;
    localparam int SETTLE_CYCLES    = PIPE_DEPTH * 4;
    localparam int RUN_LIMIT        = 5_000_000;

    // Scoreboard: keeps its own copy of the mode register and a queue of the
    // pixels the block owes us, oldest first.
    class blend_scoreboard;
        logic [2:0] mode;
        logic [7:0] pixel_q[$];
        int         errors;
        int         pairs_in;

        function new();
            mode     = MODE_ADD;
            errors   = 0;
            pairs_in = 0;
        endfunction

        function logic [7:0] blended_pixel(logic [7:0] bl, logic [7:0] ba);
            logic [8:0] sum;
            int         prod;
            logic [7:0] r;
            r = '0;
            case (mode)
                MODE_ADD: begin
                    sum = {1'b0, ba} + {1'b0, bl};
                    r   = (sum > {1'b0, PIX_MAX}) ? PIX_MAX : sum[7:0];
                end
                MODE_SUBTRACT:   r = (ba > bl) ? 8'(ba - bl) : '0;
                MODE_MULTIPLY: begin
                    prod = int'(ba) * int'(bl);
                    r    = 8'(prod / int'(PIX_MAX));
                end
                MODE_DIFFERENCE: r = (ba >= bl) ? 8'(ba - bl) : 8'(bl - ba);
                MODE_DIVIDE: begin
                    if (bl == '0 && ba == '0)
                        r = '0;
                    else if (bl == '0 || ba >= bl)
                        r = PIX_MAX;
                    else
                        r = 8'((int'(ba) * int'(PIX_MAX)) / int'(bl));
                end
                default:         r = '0;
            endcase
            return r;
        endfunction

        function void note_pair(logic [7:0] bl, logic [7:0] ba);
            pixel_q.push_back(blended_pixel(bl, ba));
            pairs_in++;
        endfunction

        function void check_pixel(logic [7:0] got);
            logic [7:0] want;
            if (pixel_q.size() == 0) begin
                errors++;
                $display("%0t: result pixel expected none, got %0d", $time, got);
            end else begin
                want = pixel_q.pop_front();
                if (got !== want) begin
                    errors++;
                    $display("%0t: result pixel expected %0d, got %0d", $time, want, got);
                end
            end
        endfunction
    endclass

    logic       i_clk          = 1'b0;
    logic       i_rst_n        = 1'b0;
    logic       i_in_valid     = 1'b0;
    logic       o_in_stall;
    logic [7:0] i_blend_pixel  = '0;
    logic [7:0] i_base_pixel   = '0;
    logic       o_out_valid;
    logic       i_out_stall    = 1'b0;
    logic [7:0] o_result_pixel;
    logic       i_cfg_valid    = 1'b0;
    logic       o_cfg_ready;
    logic [2:0] i_cfg_data     = '0;

    blend_scoreboard sb = new();

    // Directed pairs: both extremes, blend 0 against full base, base 0 against full
    // blend, and base below blend (with base 0 against full blend, divide computes).
    localparam logic [7:0] DIR_BLEND [DIRECTED_PAIRS] = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd200};
    localparam logic [7:0] DIR_BASE  [DIRECTED_PAIRS] = '{8'd0, 8'd255, 8'd255, 8'd0, 8'd100};
    localparam t_blend_mode DIR_MODES [5] =
        '{MODE_ADD, MODE_SUBTRACT, MODE_MULTIPLY, MODE_DIFFERENCE, MODE_DIVIDE};

    pixel_blend_mode_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_blend_pixel  (i_blend_pixel),
        .i_base_pixel   (i_base_pixel),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_result_pixel (o_result_pixel),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Hard stop in case the handshakes lock up.
    initial begin
        #RUN_LIMIT;
        $display("RESULT: ERROR");
        $finish;
    end

    // Sender gap: half the time none, mostly short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 25);
    endfunction

    // Pixel values weighted towards the edges, where saturation and clamping bite.
    function automatic logic [7:0] pick_pixel();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'($urandom_range(1, 3));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Offer one pixel pair after an optional gap, and hold it until taken.
    // Valid is only lowered when a gap follows, so it never toggles within a step.
    task automatic send_pair(logic [7:0] bl, logic [7:0] ba, int gap);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_blend_pixel <= bl;
        i_base_pixel  <= ba;
        do
            @(posedge i_clk);
        while (o_in_stall);
        sb.note_pair(bl, ba);
    endtask

    // Drop valid and wait until every owed pixel has come back.
    task automatic drain_pixels();
        i_in_valid <= 1'b0;
        while (sb.pixel_q.size() != 0)
            @(posedge i_clk);
    endtask

    // Write the mode register; only called with the pipeline empty.
    task automatic write_mode(logic [2:0] code);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= code;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.mode = code;
    endtask

    // Output side: sample on the edge, so values seen are those the edge acts on.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_pixel(o_result_pixel);
    end

    // Receiver back-pressure. Once, mid-stream, hold off for a long stretch so
    // the pipeline fills and the input is stalled; otherwise alternate free-running
    // stretches with short stalls and the odd long one.
    initial begin
        int  r;
        int  len;
        bit  level;
        bit  long_hold_done;
        long_hold_done = 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (!long_hold_done && sb.pairs_in >= LONG_HOLD_AT) begin
                long_hold_done = 1'b1;
                level          = 1'b1;
                len            = LONG_HOLD_CYCLES;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 40) begin
                    level = 1'b0;
                    len   = $urandom_range(1, 30);
                end else if (r < 90) begin
                    level = 1'b1;
                    len   = $urandom_range(1, 3);
                end else begin
                    level = 1'b1;
                    len   = $urandom_range(8, 30);
                end
            end
            repeat (len) begin
                i_out_stall <= level;
                @(posedge i_clk);
            end
        end
    end

    initial begin
        logic [2:0] code;
        bit         no_gaps;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: the corner pairs in each of the five defined modes.
        foreach (DIR_MODES[m]) begin
            write_mode(DIR_MODES[m]);
            for (int k = 0; k < DIRECTED_PAIRS; k++)
                send_pair(DIR_BLEND[k], DIR_BASE[k], pick_gap());
            drain_pixels();
        end

        // Random: walk every register code once (unused ones included), then
        // pick codes at random. Every fourth phase runs back-to-back.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            code    = (p < MODE_CODES) ? 3'(p) : 3'($urandom_range(0, MODE_CODES - 1));
            no_gaps = (p % 4 == 1);
            write_mode(code);
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                // Let the pipeline run dry once in the middle of a phase.
                if (p == PAUSE_PHASE && k == PAUSE_ITEM)
                    drain_pixels();
                send_pair(pick_pixel(), pick_pixel(), no_gaps ? 0 : pick_gap());
            end
            drain_pixels();
        end

        // Allow for any stray result that would trail the last one.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.pixel_q.size() != 0) begin
            sb.errors++;
            $display("%0t: %0d result pixels never arrived", $time, sb.pixel_q.size());
        end
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
